### hw/rtl/tea_block_cipher_whitened_unit_macros.svh
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_CIPHER_WHITENED_UNIT_MACROS_SVH
`define TEA_BLOCK_CIPHER_WHITENED_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TEA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tea unit: same-cycle check failed");
`define TEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tea unit: next-cycle check failed");
`else
`define TEA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TEA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - package
// Shared constants, register indexes, operation codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

   localparam int WORD_W      = 32;
   localparam int ROUND_W     = 8;
   localparam int CSR_INDEX_W = 3;

   localparam logic [WORD_W-1:0] TEA_DELTA     = 32'h9E37_79B9;
   localparam logic [WORD_W-1:0] TEA_NEG_DELTA = 32'h61C8_8647;

   localparam logic [ROUND_W-1:0] ROUND_TOTAL_RESET = 8'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_WORD0       = 3'd0,
      CSR_KEY_WORD1       = 3'd1,
      CSR_KEY_WORD2       = 3'd2,
      CSR_KEY_WORD3       = 3'd3,
      CSR_ROUND_TOTAL     = 3'd4,
      CSR_ODD_BLOCK_COUNT = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic phase;
      logic emit;
   } tea_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/tea_if.sv
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface tea_req_if
   import tea_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              command;
   logic [WORD_W-1:0] left_in;
   logic [WORD_W-1:0] right_in;

   modport source (output valid, output command, output left_in, output right_in,
                   input ready);
   modport sink   (input valid, input command, input left_in, input right_in,
                   output ready);
endinterface

interface tea_rsp_if
   import tea_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] left_out;
   logic [WORD_W-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/tea_block_cipher_whitened_unit.sv
// One request is processed at a time; the next is accepted once the result
// has moved to the response register. The shared mix unit does half a TEA
// round per cycle. With zero rounds the controller skips the run state.
// A request is taken while the previous response still waits in its register.
// Reset (synchronous): keys and whitening select to 0, round_total to 32.
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - top level
// Register file, controller and datapath of the whitened TEA engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tea_block_cipher_whitened_unit_macros.svh"

module tea_block_cipher_whitened_unit
   import tea_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   tea_req_if.sink                     req_chan,
   tea_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_wdata
);

   logic [WORD_W-1:0]  key_word0_ff, key_word1_ff, key_word2_ff, key_word3_ff;
   logic [ROUND_W-1:0] round_total_ff;
   logic               odd_block_count_ff;
   logic [WORD_W-1:0]  white_word0;
   logic [WORD_W-1:0]  white_word1;
   tea_cmd_type        cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word0_ff       <= '0;
         key_word1_ff       <= '0;
         key_word2_ff       <= '0;
         key_word3_ff       <= '0;
         round_total_ff     <= ROUND_TOTAL_RESET;
         odd_block_count_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_WORD0:       key_word0_ff       <= csr_wdata;
            CSR_KEY_WORD1:       key_word1_ff       <= csr_wdata;
            CSR_KEY_WORD2:       key_word2_ff       <= csr_wdata;
            CSR_KEY_WORD3:       key_word3_ff       <= csr_wdata;
            CSR_ROUND_TOTAL:     round_total_ff     <= csr_wdata[ROUND_W-1:0];
            CSR_ODD_BLOCK_COUNT: odd_block_count_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign white_word0 = odd_block_count_ff ? key_word2_ff : key_word0_ff;
   assign white_word1 = odd_block_count_ff ? key_word3_ff : key_word1_ff;

   tea_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .round_total (round_total_ff),
      .cmd         (cmd)
   );

   tea_dpath u_dpath (
      .clock       (clock),
      .cmd         (cmd),
      .command     (req_chan.command),
      .left_in     (req_chan.left_in),
      .right_in    (req_chan.right_in),
      .key_word0   (key_word0_ff),
      .key_word1   (key_word1_ff),
      .key_word2   (key_word2_ff),
      .key_word3   (key_word3_ff),
      .white_word0 (white_word0),
      .white_word1 (white_word1),
      .round_total (round_total_ff),
      .left_out    (rsp_chan.left_out),
      .right_out   (rsp_chan.right_out)
   );

   `TEA_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `TEA_ASSERT_IMPL(a_emit_into_free_slot, clock, reset, cmd.emit, !rsp_chan.valid || rsp_chan.ready)
   `TEA_ASSERT_NEXT(a_emit_shows_result, clock, reset, cmd.emit, rsp_chan.valid)
   `TEA_ASSERT_IMPL(a_single_command, clock, reset, cmd.load, !cmd.step && !cmd.emit)

endmodule

`default_nettype wire

### hw/rtl/tea_ctrl.sv
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - controller
// Sequences load, half-round steps and result hand-off; owns the round count.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_ctrl
   import tea_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [ROUND_W-1:0] round_total,
   output      tea_cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff,     state_in;
   logic [ROUND_W-1:0] count_ff,     count_in;
   logic               phase_ff,     phase_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.phase = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = round_total;
               phase_in = 1'b0;
               state_in = (round_total == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            phase_in = ~phase_ff;
            if (phase_ff) begin
               count_in = count_ff - 1'b1;
               if (count_ff == ROUND_W'(1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/tea_dpath.sv
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - datapath
// Block words, round sum, one shared mix unit (half a round per step) and
// the output register with whitening.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_dpath
   import tea_pkg::*;
(
   input  wire logic               clock,
   input  wire tea_cmd_type        cmd,
   input  wire logic               command,
   input  wire logic [WORD_W-1:0]  left_in,
   input  wire logic [WORD_W-1:0]  right_in,
   input  wire logic [WORD_W-1:0]  key_word0,
   input  wire logic [WORD_W-1:0]  key_word1,
   input  wire logic [WORD_W-1:0]  key_word2,
   input  wire logic [WORD_W-1:0]  key_word3,
   input  wire logic [WORD_W-1:0]  white_word0,
   input  wire logic [WORD_W-1:0]  white_word1,
   input  wire logic [ROUND_W-1:0] round_total,
   output      logic [WORD_W-1:0]  left_out,
   output      logic [WORD_W-1:0]  right_out
);

   logic [WORD_W-1:0] v0_ff,    v0_in;
   logic [WORD_W-1:0] v1_ff,    v1_in;
   logic [WORD_W-1:0] sum_ff,   sum_in;
   logic              dec_ff,   dec_in;
   logic              whiten_ff, whiten_in;
   logic [WORD_W-1:0] left_out_ff,  left_out_in;
   logic [WORD_W-1:0] right_out_ff, right_out_in;

   logic              rounds_on;
   logic              load_dec;
   logic              upper;
   logic [WORD_W-1:0] src;
   logic [WORD_W-1:0] key_a;
   logic [WORD_W-1:0] key_b;
   logic [WORD_W-1:0] target;
   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] updated;

   assign rounds_on = (round_total != '0);
   assign load_dec  = (op_type'(command) == OP_DECRYPT);

   // upper half: v1 updated from v0 with key words 2 and 3
   assign upper  = cmd.phase ^ dec_ff;
   assign src    = upper ? v0_ff : v1_ff;
   assign target = upper ? v1_ff : v0_ff;
   assign key_a  = upper ? key_word2 : key_word0;
   assign key_b  = upper ? key_word3 : key_word1;
   assign mix    = ((src << 4) + key_a) ^ (src + sum_ff) ^ ((src >> 5) + key_b);
   assign updated = dec_ff ? (target - mix) : (target + mix);

   always_comb begin
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      sum_in       = sum_ff;
      dec_in       = dec_ff;
      whiten_in    = whiten_ff;
      left_out_in  = left_out_ff;
      right_out_in = right_out_ff;
      if (cmd.load) begin
         dec_in    = load_dec;
         whiten_in = !load_dec && rounds_on;
         if (load_dec && rounds_on) begin
            v0_in = left_in ^ white_word0;
            v1_in = right_in ^ white_word1;
         end else begin
            v0_in = left_in;
            v1_in = right_in;
         end
         sum_in = load_dec ? WORD_W'(TEA_DELTA * WORD_W'(round_total)) : TEA_DELTA;
      end
      if (cmd.step) begin
         if (upper) begin
            v1_in = updated;
         end else begin
            v0_in = updated;
         end
         if (cmd.phase) begin
            sum_in = sum_ff + (dec_ff ? TEA_NEG_DELTA : TEA_DELTA);
         end
      end
      if (cmd.emit) begin
         left_out_in  = whiten_ff ? (v0_ff ^ white_word0) : v0_ff;
         right_out_in = whiten_ff ? (v1_ff ^ white_word1) : v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      v0_ff        <= v0_in;
      v1_ff        <= v1_in;
      sum_ff       <= sum_in;
      dec_ff       <= dec_in;
      whiten_ff    <= whiten_in;
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
   end

   assign left_out  = left_out_ff;
   assign right_out = right_out_ff;

endmodule

`default_nettype wire

### tb/tea_block_checker.sv
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - checker
// Watches the request, response and register ports. It keeps its own copy of
// the key, round count and whitening select. It computes the processed block
// for every accepted request and compares each accepted response with the
// oldest one still waiting.
// ----------------------------------------------------------------------------
module tea_block_checker
   import tea_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   tea_req_if                     req_mon,
   tea_rsp_if                     rsp_mon,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata,
   output int                     mismatch_count,
   output int                     blocks_in_flight
);

   typedef struct packed {
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } tea_block_type;

   logic [WORD_W-1:0]  key_word [4];
   logic [ROUND_W-1:0] round_total;
   logic               odd_block_count;
   tea_block_type      expected_blocks [$];

   initial begin
      mismatch_count   = 0;
      blocks_in_flight = 0;
   end

   function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] w, sum, ka, kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

   function automatic tea_block_type cipher_block(input op_type op, input tea_block_type blk);
      logic [WORD_W-1:0] v0, v1, w0, w1, sum;
      int                r;
      v0 = blk.left;
      v1 = blk.right;
      w0 = odd_block_count ? key_word[2] : key_word[0];
      w1 = odd_block_count ? key_word[3] : key_word[1];
      // zero rounds: no whitening either way
      if (round_total != '0) begin
         if (op == OP_ENCRYPT) begin
            sum = '0;
            for (r = 0; r < round_total; r++) begin
               sum = sum + TEA_DELTA;
               v0  = v0 + feistel_mix(v1, sum, key_word[0], key_word[1]);
               v1  = v1 + feistel_mix(v0, sum, key_word[2], key_word[3]);
            end
            v0 = v0 ^ w0;
            v1 = v1 ^ w1;
         end else begin
            v0  = v0 ^ w0;
            v1  = v1 ^ w1;
            sum = TEA_DELTA * round_total;
            for (r = 0; r < round_total; r++) begin
               v1  = v1 - feistel_mix(v0, sum, key_word[2], key_word[3]);
               v0  = v0 - feistel_mix(v1, sum, key_word[0], key_word[1]);
               sum = sum + TEA_NEG_DELTA;
            end
         end
      end
      return '{left: v0, right: v1};
   endfunction

   task automatic report_mismatch(input string note);
      $display("[%0t] tea checker: %s", $realtime, note);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      tea_block_type want;
      if (reset) begin
         key_word        = '{default: '0};
         round_total     = ROUND_TOTAL_RESET;
         odd_block_count = 1'b0;
         expected_blocks.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch($sformatf("response %h_%h with no request pending",
                                         rsp_mon.left_out, rsp_mon.right_out));
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_mon.left_out !== want.left) begin
                  report_mismatch($sformatf("left_out %h, expected %h",
                                            rsp_mon.left_out, want.left));
               end
               if (rsp_mon.right_out !== want.right) begin
                  report_mismatch($sformatf("right_out %h, expected %h",
                                            rsp_mon.right_out, want.right));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_blocks.push_back(cipher_block(op_type'(req_mon.command),
                                                   {req_mon.left_in, req_mon.right_in}));
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_KEY_WORD0:       key_word[0]     = csr_wdata;
               CSR_KEY_WORD1:       key_word[1]     = csr_wdata;
               CSR_KEY_WORD2:       key_word[2]     = csr_wdata;
               CSR_KEY_WORD3:       key_word[3]     = csr_wdata;
               CSR_ROUND_TOTAL:     round_total     = csr_wdata[ROUND_W-1:0];
               CSR_ODD_BLOCK_COUNT: odd_block_count = csr_wdata[0];
               default: ;
            endcase
         end
      end
      blocks_in_flight <= expected_blocks.size();
   end

endmodule

### tb/tea_block_cipher_whitened_unit_tb.sv
// ----------------------------------------------------------------------------
// TEA whitened cipher unit - testbench top
// Drives encrypt and decrypt requests through the unit under a series of key,
// round count and whitening settings. It starts with the extremes: zero rounds,
// the largest round count, all-zero and all-one keys and words. Then it sends
// random batches with bursty stalls on both sides, two long response hold-offs
// and a calm tail without stalls. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module tea_block_cipher_whitened_unit_tb;
   import tea_pkg::*;

   localparam int ITEM_TOTAL      = 1750;
   localparam int CALM_TAIL       = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 20000;

   // indexes past the register list, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;
   int                     mismatch_count;
   int                     blocks_in_flight;
   int                     blocks_sent;
   logic [ROUND_W-1:0]     rounds_now;
   bit                     src_stalls;
   bit                     sink_stalls;
   bit                     hold_off_pending;

   tea_req_if req_chan ();
   tea_rsp_if rsp_chan ();

   tea_block_cipher_whitened_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   tea_block_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .blocks_in_flight (blocks_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // high bits above each register's width carry junk half the time
   task automatic program_regs(input logic [WORD_W-1:0] k0, k1, k2, k3,
                               input logic [ROUND_W-1:0] rounds, input logic odd);
      put_reg(CSR_KEY_WORD0, k0);
      put_reg(CSR_KEY_WORD1, k1);
      put_reg(CSR_KEY_WORD2, k2);
      put_reg(CSR_KEY_WORD3, k3);
      put_reg(CSR_ROUND_TOTAL, {($urandom_range(0, 1) ? 24'($urandom) : 24'h0), rounds});
      put_reg(CSR_ODD_BLOCK_COUNT, {($urandom_range(0, 1) ? 31'($urandom) : 31'h0), odd});
      if ($urandom_range(0, 1)) begin
         put_reg(CSR_SPARE_LO, $urandom);
         put_reg(CSR_SPARE_HI, $urandom);
      end
      rounds_now   = rounds;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_block(input op_type op, input logic [WORD_W-1:0] left_word, right_word);
      if (src_stalls && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.command  <= op;
      req_chan.left_in  <= left_word;
      req_chan.right_in <= right_word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      blocks_sent++;
   endtask

   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (blocks_in_flight != 0) @(posedge clock);
      repeat (2 * rounds_now + 4) @(posedge clock);
   endtask

   // response side: bursts of ready and of stall, plus the requested hold-off
   initial begin : drive_rsp_ready
      int span;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            span = HOLD_OFF_CYCLES;
         end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            span = $urandom_range(1, 19);
         end else begin
            rsp_chan.ready <= 1'b1;
            span = sink_stalls ? $urandom_range(1, 60) : 1;
         end
         repeat (span - 1) @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int                 phase;
      int                 batch;
      int                 pick;
      logic [ROUND_W-1:0] rounds;
      blocks_sent      = 0;
      rounds_now       = ROUND_TOTAL_RESET;
      src_stalls       = 1'b1;
      sink_stalls      = 1'b1;
      hold_off_pending = 1'b0;
      reset             <= 1'b1;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_KEY_WORD0;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.command  <= OP_ENCRYPT;
      req_chan.left_in  <= '0;
      req_chan.right_in <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero key, 32 rounds, low key pair for whitening
      push_block(OP_ENCRYPT, '0, '0);
      push_block(OP_DECRYPT, '0, '0);
      push_block(OP_ENCRYPT, '1, '1);
      finish_phase();

      // largest round count, all-ones key, high key pair
      program_regs('1, '1, '1, '1, 8'd255, 1'b1);
      push_block(OP_ENCRYPT, '0, '1);
      push_block(OP_DECRYPT, '1, '0);
      push_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      finish_phase();

      // zero rounds pass the block through in both directions
      program_regs(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, 8'd0, 1'b1);
      push_block(OP_ENCRYPT, '1, '0);
      push_block(OP_DECRYPT, '0, '1);
      push_block(OP_DECRYPT, 32'hDEAD_BEEF, 32'hCAFE_F00D);
      finish_phase();

      // single round, distinct pairs so a wrong whitening choice shows
      program_regs(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 8'd1, 1'b0);
      push_block(OP_ENCRYPT, '0, '0);
      push_block(OP_DECRYPT, '0, '0);
      push_block(OP_ENCRYPT, '1, 32'h7FFF_FFFF);
      push_block(OP_DECRYPT, 32'h7FFF_FFFF, '1);
      finish_phase();

      program_regs('0, '1, '0, '1, 8'd2, 1'b1);
      push_block(OP_ENCRYPT, '0, '0);
      push_block(OP_DECRYPT, '1, '1);
      push_block(OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
      push_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
      finish_phase();

      phase = 0;
      while (blocks_sent < ITEM_TOTAL) begin
         if (ITEM_TOTAL - blocks_sent <= CALM_TAIL) begin
            src_stalls  = 1'b0;
            sink_stalls = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            rounds = '0;
         end else if (pick < 55) begin
            rounds = ROUND_W'($urandom_range(1, 8));
         end else if (pick < 92) begin
            rounds = ROUND_W'($urandom_range(9, 40));
         end else if (pick < 96) begin
            rounds = 8'd255;
         end else begin
            rounds = ROUND_W'($urandom_range(41, 254));
         end
         program_regs(pick_word(), pick_word(), pick_word(), pick_word(), rounds,
                      1'($urandom_range(0, 1)));
         if (phase == 2 || phase == 9) begin
            hold_off_pending = 1'b1;
         end
         batch = (rounds > 40) ? $urandom_range(3, 8) : $urandom_range(30, 110);
         repeat (batch) begin
            push_block(op_type'($urandom_range(0, 1)), pick_word(), pick_word());
         end
         finish_phase();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### tea_block_cipher_whitened_unit.f
+incdir+hw/rtl
hw/rtl/tea_pkg.sv
hw/rtl/tea_if.sv
hw/rtl/tea_ctrl.sv
hw/rtl/tea_dpath.sv
hw/rtl/tea_block_cipher_whitened_unit.sv
tb/tea_block_checker.sv
tb/tea_block_cipher_whitened_unit_tb.sv
